// ===== hw/rtl/dmhr_pkg.sv =====
package dmhr_pkg;

  // default depth of the word store
  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  // count width for the default depth
  localparam int unsigned CNT_W_DEF = $clog2(CAPACITY_DEF + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SWAP       = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_MID  = 3'd2,
    S_CAPT = 3'd3,
    S_RESP = 3'd4
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the accepted operation
    logic exec;   // apply the operation, issue pop read
    logic mid;    // take popped word, issue middle read
    logic capt;   // capture middle word into the result
  } cmd_t;

endpackage

// ===== hw/rtl/dmhr_if.sv =====
// operation channel
interface dmhr_req_if import dmhr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] value_in;

  modport source (output valid, output op, output value_in, input ready);
  modport sink   (input valid, input op, input value_in, output ready);
endinterface

// result channel
interface dmhr_rsp_if import dmhr_pkg::*; #(
  parameter int unsigned CNT_W = CNT_W_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value_out;
  logic [CNT_W-1:0]         size_now;
  logic signed [WORD_W-1:0] middle_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output value_out, output size_now, output middle_value,
                  output status, input ready);
  modport sink   (input valid, input value_out, input size_now, input middle_value,
                  input status, output ready);
endinterface

// ===== hw/rtl/deque_with_middle_and_half_rotate_core.sv =====
// Bounded double-ended queue of signed 32-bit words with middle tracking. One operation
// per request (push front/back, pop front/back, swap, query) and exactly one result per
// request, giving the popped word, the size, the word at index floor(size/2) and a status.
// Swap rotates by moving the front pointer, so no words are copied. One operation is in
// flight at a time: a result is valid once the request has passed the execute, middle and
// capture states, and the next request is taken in the cycle after the result transfer.
// The single read port of the word store serves the pop read and then the middle read,
// each with a registered output. The store is not cleared at reset; only written words
// are ever read.
module deque_with_middle_and_half_rotate_core import dmhr_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  dmhr_req_if.sink    req_i,
  dmhr_rsp_if.source  rsp_o
);

  cmd_t cmd;

  dmhr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  dmhr_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (req_i.op),
    .value_in_i     (req_i.value_in),
    .value_out_o    (rsp_o.value_out),
    .size_now_o     (rsp_o.size_now),
    .middle_value_o (rsp_o.middle_value),
    .status_o       (rsp_o.status)
  );

endmodule

// ===== hw/rtl/dmhr_ctrl.sv =====
module dmhr_ctrl import dmhr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_MID;
      S_MID:  state_d = S_CAPT;
      S_CAPT: state_d = S_RESP;
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_MID:  cmd_o.mid  = 1'b1;
      S_CAPT: cmd_o.capt = 1'b1;
      S_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.latch, cmd_o.exec, cmd_o.mid, cmd_o.capt}))
    else $error("more than one datapath command");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("new operation taken while a result is pending");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd_o.exec)
    else $error("accepted operation not executed");
`endif

endmodule

// ===== hw/rtl/dmhr_datapath.sv =====
module dmhr_datapath import dmhr_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [WORD_W-1:0] value_in_i,
  output logic signed [WORD_W-1:0] value_out_o,
  output logic [CW-1:0]            size_now_o,
  output logic signed [WORD_W-1:0] middle_value_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam logic [AW:0]   CapExt   = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapCnt   = CW'(CAPACITY);

  // circular slot of position pos counted from base
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= CapExt) sum = sum - CapExt;
    return sum[AW-1:0];
  endfunction

  logic [WORD_W-1:0] mem_q [CAPACITY];
  logic [WORD_W-1:0] rd_data_q;

  op_e               op_q;
  logic [WORD_W-1:0] val_q;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  status_e           stat_q, stat_d;
  logic              pop_q, pop_d;
  logic [WORD_W-1:0] popped_q, popped_d;
  logic [WORD_W-1:0] middle_q;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CW-1:0]     cnt_m1, half_cnt;
  logic              full, empty;

  assign full     = (count_q == CapCnt);
  assign empty    = (count_q == '0);
  assign cnt_m1   = count_q - 1'b1;
  assign half_cnt = count_q >> 1;

  // operation decode, pointer and count update, memory commands
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    stat_d   = stat_q;
    pop_d    = pop_q;
    popped_d = popped_q;
    wr_en    = 1'b0;
    wr_addr  = front_q;
    rd_en    = 1'b0;
    rd_addr  = front_q;
    if (cmd_i.exec) begin
      stat_d   = ST_OK;
      pop_d    = 1'b0;
      popped_d = '0;
      case (op_q)
        OP_PUSH_FRONT: begin
          if (full) begin
            stat_d = ST_FULL;
          end else begin
            front_d = (front_q == '0) ? LastSlot : front_q - 1'b1;
            wr_en   = 1'b1;
            wr_addr = front_d;
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            stat_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = slot_of(front_q, count_q[AW-1:0]);
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            stat_d = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = front_q;
            pop_d   = 1'b1;
            front_d = (front_q == LastSlot) ? '0 : front_q + 1'b1;
            count_d = cnt_m1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            stat_d = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot_of(front_q, cnt_m1[AW-1:0]);
            pop_d   = 1'b1;
            count_d = cnt_m1;
          end
        end
        // rotation is a pointer move only
        OP_SWAP: front_d = slot_of(front_q, half_cnt[AW-1:0]);
        default: ;
      endcase
    end else if (cmd_i.mid) begin
      if (pop_q) popped_d = rd_data_q;
      rd_en   = !empty;
      rd_addr = slot_of(front_q, half_cnt[AW-1:0]);
    end
  end

  // word store
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= val_q;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      stat_q  <= ST_OK;
      pop_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      stat_q  <= stat_d;
      pop_q   <= pop_d;
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_e'(op_i);
      val_q <= value_in_i;
    end
    popped_q <= popped_d;
    if (cmd_i.capt) middle_q <= empty ? '0 : rd_data_q;
  end

  assign value_out_o    = popped_q;
  assign size_now_o     = count_q;
  assign middle_value_o = middle_q;
  assign status_o       = stat_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CapCnt) && (front_q <= LastSlot))
    else $error("count or front pointer out of range");
  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && stat_d != ST_OK) |=> ($stable(count_q) && $stable(front_q)))
    else $error("failed operation changed the queue");
  a_step_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
                    || count_q == $past(count_q) - 1'b1))
    else $error("count moved by more than one");
  a_mid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capt && empty) |=> (middle_value_o == '0))
    else $error("middle word not zero on empty queue");
`endif

endmodule
